FILE: rtl/scd_pkg.sv
// Shared constants, types and tables for the stick command decoder.
package scd_pkg;

  // Field widths
  localparam int PULSE_W   = 12;
  localparam int ELAPSED_W = 10;
  localparam int CODE_W    = 5;
  localparam int PAT_W     = 8;
  localparam int HOLD_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 1'd1;

  localparam logic [PULSE_W-1:0] LOW_THRESHOLD_RST  = 12'd1050;
  localparam logic [PULSE_W-1:0] HIGH_THRESHOLD_RST = 12'd1900;

  // Hold timing in milliseconds
  localparam logic signed [HOLD_W-1:0] HOLD_MIN_MS = 16'sd50;
  localparam logic signed [HOLD_W-1:0] REPEAT_MS   = 16'sd250;
  localparam logic signed [HOLD_W:0]   HOLD_MAX    = 17'sd32767;

  // Command codes
  localparam logic [CODE_W-1:0] CMD_NONE          = 5'd0;
  localparam logic [CODE_W-1:0] CMD_GYRO_CAL      = 5'd1;
  localparam logic [CODE_W-1:0] CMD_INFLIGHT_ACC  = 5'd2;
  localparam logic [CODE_W-1:0] CMD_PID_PROFILE_1 = 5'd3;
  localparam logic [CODE_W-1:0] CMD_PID_PROFILE_2 = 5'd4;
  localparam logic [CODE_W-1:0] CMD_PID_PROFILE_3 = 5'd5;
  localparam logic [CODE_W-1:0] CMD_SAVE          = 5'd6;
  localparam logic [CODE_W-1:0] CMD_ACC_CAL       = 5'd7;
  localparam logic [CODE_W-1:0] CMD_MAG_CAL       = 5'd8;
  localparam logic [CODE_W-1:0] CMD_TRIM_SAVE     = 5'd9;
  localparam logic [CODE_W-1:0] CMD_GAIN_TRIM_0   = 5'd10;
  localparam logic [CODE_W-1:0] CMD_RATE_PROF_0   = 5'd26;

  // Stick classes
  localparam logic [1:0] CLS_LO = 2'd1;
  localparam logic [1:0] CLS_HI = 2'd2;
  localparam logic [1:0] CLS_CE = 2'd3;

  localparam logic [PAT_W-1:0] THR_FIELD = 8'hC0;
  localparam logic [PAT_W-1:0] THR_HIGH  = 8'h80;

  // Pack four classes: throttle, yaw, pitch, roll
  function automatic logic [PAT_W-1:0] pat(input logic [1:0] t, input logic [1:0] y,
                                           input logic [1:0] p, input logic [1:0] r);
    pat = {t, y, p, r};
  endfunction

  // Fixed combinations
  localparam logic [PAT_W-1:0] PAT_GYRO_CAL     = pat(CLS_LO, CLS_LO, CLS_LO, CLS_CE);
  localparam logic [PAT_W-1:0] PAT_INFLIGHT_ACC = pat(CLS_LO, CLS_LO, CLS_HI, CLS_HI);
  localparam logic [PAT_W-1:0] PAT_PID_1        = pat(CLS_LO, CLS_LO, CLS_CE, CLS_LO);
  localparam logic [PAT_W-1:0] PAT_PID_2        = pat(CLS_LO, CLS_LO, CLS_HI, CLS_CE);
  localparam logic [PAT_W-1:0] PAT_PID_3        = pat(CLS_LO, CLS_LO, CLS_CE, CLS_HI);
  localparam logic [PAT_W-1:0] PAT_SAVE         = pat(CLS_LO, CLS_LO, CLS_LO, CLS_HI);
  localparam logic [PAT_W-1:0] PAT_ACC_CAL      = pat(CLS_HI, CLS_LO, CLS_LO, CLS_CE);
  localparam logic [PAT_W-1:0] PAT_MAG_CAL      = pat(CLS_HI, CLS_HI, CLS_LO, CLS_CE);

  // Gain trim combinations, in code order
  localparam logic [PAT_W-1:0] TRIM_TABLE [16] = '{
    pat(CLS_CE, CLS_LO, CLS_HI, CLS_CE), pat(CLS_CE, CLS_LO, CLS_LO, CLS_CE),
    pat(CLS_CE, CLS_LO, CLS_CE, CLS_HI), pat(CLS_CE, CLS_LO, CLS_CE, CLS_LO),
    pat(CLS_HI, CLS_CE, CLS_HI, CLS_CE), pat(CLS_HI, CLS_CE, CLS_LO, CLS_CE),
    pat(CLS_HI, CLS_CE, CLS_CE, CLS_HI), pat(CLS_HI, CLS_CE, CLS_CE, CLS_LO),
    pat(CLS_CE, CLS_HI, CLS_HI, CLS_CE), pat(CLS_CE, CLS_HI, CLS_LO, CLS_CE),
    pat(CLS_CE, CLS_HI, CLS_CE, CLS_HI), pat(CLS_CE, CLS_HI, CLS_CE, CLS_LO),
    pat(CLS_CE, CLS_CE, CLS_HI, CLS_CE), pat(CLS_CE, CLS_CE, CLS_LO, CLS_CE),
    pat(CLS_CE, CLS_CE, CLS_CE, CLS_HI), pat(CLS_CE, CLS_CE, CLS_CE, CLS_LO)
  };

  // Rate profile combinations, in code order
  localparam logic [PAT_W-1:0] RATE_TABLE [4] = '{
    pat(CLS_HI, CLS_CE, CLS_HI, CLS_CE), pat(CLS_HI, CLS_CE, CLS_LO, CLS_CE),
    pat(CLS_HI, CLS_CE, CLS_CE, CLS_HI), pat(CLS_HI, CLS_CE, CLS_CE, CLS_LO)
  };

  // One input word as held in the input register
  typedef struct packed {
    logic [PULSE_W-1:0]   roll_pulse;
    logic [PULSE_W-1:0]   pitch_pulse;
    logic [PULSE_W-1:0]   yaw_pulse;
    logic [PULSE_W-1:0]   throttle_pulse;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 armed;
    logic                 motion_blocked;
    logic                 level_mode;
  } in_word_t;

  // Bit 1: above low threshold, bit 0: below high threshold
  function automatic logic [1:0] classify(input logic [PULSE_W-1:0] v,
                                          input logic [PULSE_W-1:0] lo,
                                          input logic [PULSE_W-1:0] hi);
    classify = {v > lo, v < hi};
  endfunction

endpackage

FILE: rtl/scd_in_if.sv
// Input channel: one frame of stick pulses, timing and flags.
interface scd_in_if;
  logic                          valid;
  logic                          ready;
  logic [scd_pkg::PULSE_W-1:0]   roll_pulse;
  logic [scd_pkg::PULSE_W-1:0]   pitch_pulse;
  logic [scd_pkg::PULSE_W-1:0]   yaw_pulse;
  logic [scd_pkg::PULSE_W-1:0]   throttle_pulse;
  logic [scd_pkg::ELAPSED_W-1:0] elapsed_ms;
  logic                          armed;
  logic                          motion_blocked;
  logic                          level_mode;

  modport source (output valid, output roll_pulse, output pitch_pulse, output yaw_pulse,
                  output throttle_pulse, output elapsed_ms, output armed,
                  output motion_blocked, output level_mode, input ready);
  modport sink (input valid, input roll_pulse, input pitch_pulse, input yaw_pulse,
                input throttle_pulse, input elapsed_ms, input armed,
                input motion_blocked, input level_mode, output ready);
endinterface

FILE: rtl/scd_out_if.sv
// Result channel: command code and packed stick pattern.
interface scd_out_if;
  logic                       valid;
  logic                       ready;
  logic [scd_pkg::CODE_W-1:0] command_code;
  logic [scd_pkg::PAT_W-1:0]  stick_pattern;

  modport source (output valid, output command_code, output stick_pattern, input ready);
  modport sink (input valid, input command_code, input stick_pattern, output ready);
endinterface

FILE: rtl/stick_command_decoder_unit.sv
// Stick command decoder: classify sticks, time the hold and decode commands.
//
//  channel   | dir | handshake   | word
//  ----------+-----+-------------+---------------------------------------------
//  in_chan   | in  | valid/ready | four pulses, elapsed_ms, armed, blocked, level
//  out_chan  | out | valid/ready | command_code, stick_pattern
//  cfg_*     | in  | we only     | index 0 low threshold, 1 high threshold
//
// One word per cycle while the result is not stalled. A word is taken into the
// input register and decoded from there into the result register. Reset
// (rst_n, synchronous) clears thresholds to their defaults and hold state to
// zero. A stalled result holds; the input register keeps accepting while the
// result register is free or being taken.
module stick_command_decoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  scd_in_if.sink                           in_chan,
  scd_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scd_pkg::PULSE_W-1:0]      cfg_wdata
);

  logic [scd_pkg::PULSE_W-1:0]        low_thr_r;
  logic [scd_pkg::PULSE_W-1:0]        high_thr_r;

  logic                               s1_valid_r;
  scd_pkg::in_word_t                  s1_r;

  logic signed [scd_pkg::HOLD_W-1:0]  hold_time_r, hold_time_nxt;
  logic [scd_pkg::PAT_W-1:0]          last_pattern_r;
  logic                               repeat_lock_r, repeat_lock_nxt;
  logic                               save_pending_r, save_pending_nxt;

  logic                               out_valid_r;
  logic [scd_pkg::CODE_W-1:0]         out_code_r, out_code_nxt;
  logic [scd_pkg::PAT_W-1:0]          out_pattern_r;

  logic                               s1_fire;
  logic                               in_fire;
  logic [scd_pkg::PAT_W-1:0]          pattern;
  logic signed [scd_pkg::HOLD_W:0]    hold_sum;

  // Handshake
  assign s1_fire       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.command_code  = out_code_r;
  assign out_chan.stick_pattern = out_pattern_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= scd_pkg::LOW_THRESHOLD_RST;
      high_thr_r <= scd_pkg::HIGH_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        scd_pkg::REG_LOW_THRESHOLD:  low_thr_r  <= cfg_wdata;
        scd_pkg::REG_HIGH_THRESHOLD: high_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.roll_pulse     <= in_chan.roll_pulse;
      s1_r.pitch_pulse    <= in_chan.pitch_pulse;
      s1_r.yaw_pulse      <= in_chan.yaw_pulse;
      s1_r.throttle_pulse <= in_chan.throttle_pulse;
      s1_r.elapsed_ms     <= in_chan.elapsed_ms;
      s1_r.armed          <= in_chan.armed;
      s1_r.motion_blocked <= in_chan.motion_blocked;
      s1_r.level_mode     <= in_chan.level_mode;
    end
  end

  // Classify and pack the sticks
  assign pattern = {scd_pkg::classify(s1_r.throttle_pulse, low_thr_r, high_thr_r),
                    scd_pkg::classify(s1_r.yaw_pulse,      low_thr_r, high_thr_r),
                    scd_pkg::classify(s1_r.pitch_pulse,    low_thr_r, high_thr_r),
                    scd_pkg::classify(s1_r.roll_pulse,     low_thr_r, high_thr_r)};

  assign hold_sum = {hold_time_r[scd_pkg::HOLD_W-1], hold_time_r}
                  + {7'd0, s1_r.elapsed_ms};

  // Hold timing and command decode
  always_comb begin
    logic signed [scd_pkg::HOLD_W-1:0] hold_upd;
    logic                              lock_upd;
    logic                              trim_hit;
    logic [3:0]                        trim_idx;
    logic                              rate_hit;
    logic [1:0]                        rate_idx;
    logic [scd_pkg::CODE_W-1:0]        code;

    hold_upd = hold_time_r;
    lock_upd = repeat_lock_r;
    trim_hit = 1'b0;
    trim_idx = 4'd0;
    rate_hit = 1'b0;
    rate_idx = 2'd0;
    code     = scd_pkg::CMD_NONE;

    hold_time_nxt    = hold_time_r;
    repeat_lock_nxt  = repeat_lock_r;
    save_pending_nxt = save_pending_r;

    // advance or restart the hold
    if (pattern == last_pattern_r) begin
      if (hold_sum <= scd_pkg::HOLD_MAX) begin
        hold_upd = hold_sum[scd_pkg::HOLD_W-1:0];
      end
    end else begin
      hold_upd = '0;
      lock_upd = 1'b0;
    end

    for (int i = 0; i < 16; i++) begin
      if (!trim_hit && pattern == scd_pkg::TRIM_TABLE[i]) begin
        trim_hit = 1'b1;
        trim_idx = 4'(i);
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (!rate_hit && pattern == scd_pkg::RATE_TABLE[i]) begin
        rate_hit = 1'b1;
        rate_idx = 2'(i);
      end
    end

    hold_time_nxt   = hold_upd;
    repeat_lock_nxt = lock_upd;

    // evaluate the held pattern once; a gain trim unlocks it to repeat
    if (!s1_r.armed && !lock_upd && hold_upd > scd_pkg::HOLD_MIN_MS
        && !s1_r.motion_blocked) begin
      repeat_lock_nxt = 1'b1;
      if (pattern == scd_pkg::PAT_GYRO_CAL) begin
        code = scd_pkg::CMD_GYRO_CAL;
      end else if (pattern == scd_pkg::PAT_INFLIGHT_ACC) begin
        code = scd_pkg::CMD_INFLIGHT_ACC;
      end else if (pattern == scd_pkg::PAT_PID_1) begin
        code = scd_pkg::CMD_PID_PROFILE_1;
      end else if (pattern == scd_pkg::PAT_PID_2) begin
        code = scd_pkg::CMD_PID_PROFILE_2;
      end else if (pattern == scd_pkg::PAT_PID_3) begin
        code = scd_pkg::CMD_PID_PROFILE_3;
      end else if (pattern == scd_pkg::PAT_ACC_CAL) begin
        code = scd_pkg::CMD_ACC_CAL;
      end else if (pattern == scd_pkg::PAT_MAG_CAL) begin
        code = scd_pkg::CMD_MAG_CAL;
      end else begin
        // save falls through to the mode-specific checks
        if (pattern == scd_pkg::PAT_SAVE) begin
          code = scd_pkg::CMD_SAVE;
        end
        if (s1_r.level_mode) begin
          if (save_pending_r && (pattern & scd_pkg::THR_FIELD) != scd_pkg::THR_HIGH) begin
            save_pending_nxt = 1'b0;
            code             = scd_pkg::CMD_TRIM_SAVE;
          end else if (trim_hit) begin
            save_pending_nxt = 1'b1;
            hold_time_nxt    = hold_upd - scd_pkg::REPEAT_MS;
            repeat_lock_nxt  = 1'b0;
            code             = scd_pkg::CMD_GAIN_TRIM_0 + {1'b0, trim_idx};
          end
        end else if (rate_hit) begin
          code = scd_pkg::CMD_RATE_PROF_0 + {3'd0, rate_idx};
        end
      end
    end

    out_code_nxt = code;
  end

  // Hold state, advanced once per decoded word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r    <= '0;
      last_pattern_r <= '0;
      repeat_lock_r  <= 1'b0;
      save_pending_r <= 1'b0;
    end else if (s1_fire) begin
      hold_time_r    <= hold_time_nxt;
      last_pattern_r <= pattern;
      repeat_lock_r  <= repeat_lock_nxt;
      save_pending_r <= save_pending_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_code_r    <= out_code_nxt;
      out_pattern_r <= pattern;
    end
  end

endmodule
